[rtl/tbrl_pkg.sv]
// Shared constants, datapath opcodes and status type for the token bucket rate limiter.
`timescale 1ns / 1ps

package tbrl_pkg;

    localparam int TICKS_PER_SECOND = 1000000;

    localparam int RATE_W    = 40;   // fill rate, Q24.16 bytes per tick
    localparam int TOK_W     = 40;   // token level, Q24.16 bytes
    localparam int TIME_W    = 48;   // timestamps in ticks
    localparam int BYTES_W   = 32;   // request size in bytes
    localparam int CAP_W     = 24;   // capacity in whole bytes
    localparam int WAIT_W    = 40;   // wait result in ticks
    localparam int FRAC_BITS = 16;
    localparam int QUARTER_SHIFT = 2;

    localparam int NEED_W = BYTES_W + FRAC_BITS;     // request in Q.16
    localparam int ACC_W  = RATE_W + 1;              // product saturates at 2^ACC_W
    localparam int SUM_W  = ACC_W + 2;

    localparam int MUL_STEPS = RATE_W;               // one multiplier bit per cycle
    localparam int DIV_STEPS = NEED_W;               // one quotient bit per cycle
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [CAP_W-1:0]  CAP_MIN_BYTES = CAP_W'(65536);
    localparam logic [CAP_W-1:0]  CAP_MAX_BYTES = CAP_W'(8388608);
    localparam logic [RATE_W-1:0] TPS_OPERAND   = RATE_W'(TICKS_PER_SECOND);
    localparam logic [WAIT_W-1:0] WAIT_MAX      = '1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_MUL_STEP,
        OP_CFG_FINISH,
        OP_FILL,
        OP_FREE,
        OP_SET_TIME,
        OP_REFILL_START,
        OP_REFILL_ADD,
        OP_OVER,
        OP_GRANT,
        OP_SHORT,
        OP_DIV_STEP,
        OP_ROUND,
        OP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        logic is_fill;     // captured command is a refill to full
        logic is_free;     // zero bytes or unlimited rate
        logic time_only;   // restart pending or time did not advance
        logic over;        // request larger than capacity
        logic enough;      // bucket covers the request
    } dp_status_t;

endpackage

[rtl/token_bucket_rate_limiter.sv]
// Top level of the token bucket rate limiter: controller plus datapath.
`timescale 1ns / 1ps
//
// Usage
//   fill_rate_we/fill_rate set the refill rate (bytes per tick, Q24.16, zero means
//   unlimited). A write restarts the time base and then works out the capacity
//   (a quarter second of rate, 64 KiB..8 MiB) and clamps the bucket; in_ready
//   stays low meanwhile.
//   Input channel (in_valid/in_ready) carries one transaction: cmd, now, byte_count.
//   cmd 1 fills the bucket to capacity; cmd 0 takes byte_count bytes.
//   Output channel (out_valid/out_ready) returns wait_ticks, granted, over_capacity.
//   A fill or a free take goes straight to the result; any other take refills the
//   bucket unless a restart is pending or time has not advanced, then checks it and
//   computes a wait when short or oversized. The refill is a 40-step serial multiply
//   and the wait a 48-step restoring divide, both one bit per cycle.
//   One transaction is worked on at a time; the next is taken the cycle after the
//   result moves to the output register, even while that result still waits.
//   When the receiver stalls, the finished result holds in the datapath result
//   registers and in_ready stays low until the output register frees.
//   Reset (rst_n, asynchronous) empties the bucket, zeroes rate and capacity and
//   arms the time restart; the first non-free take records its time without a refill.
//

module token_bucket_rate_limiter
    import tbrl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fill_rate_we,
    input  logic [RATE_W-1:0]   fill_rate,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                cmd,
    input  logic [TIME_W-1:0]   now,
    input  logic [BYTES_W-1:0]  byte_count,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [WAIT_W-1:0]   wait_ticks,
    output logic                granted,
    output logic                over_capacity
);

    dp_op_t     op;
    dp_status_t status;

    // Sequence the work; hold results until the receiver takes them
    tbrl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .fill_rate_we (fill_rate_we),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .op           (op)
    );

    // Bucket arithmetic and result registers
    tbrl_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .fill_rate_we  (fill_rate_we),
        .fill_rate     (fill_rate),
        .cmd           (cmd),
        .now           (now),
        .byte_count    (byte_count),
        .op            (op),
        .status        (status),
        .wait_ticks    (wait_ticks),
        .granted       (granted),
        .over_capacity (over_capacity)
    );

endmodule

[rtl/tbrl_datapath.sv]
// Datapath: bucket state, serial saturating multiplier, serial divider and result registers.
`timescale 1ns / 1ps

module tbrl_datapath
    import tbrl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fill_rate_we,
    input  logic [RATE_W-1:0]   fill_rate,
    input  logic                cmd,
    input  logic [TIME_W-1:0]   now,
    input  logic [BYTES_W-1:0]  byte_count,
    input  dp_op_t              op,
    output dp_status_t          status,
    output logic [WAIT_W-1:0]   wait_ticks,
    output logic                granted,
    output logic                over_capacity
);

    // Architectural state
    logic [RATE_W-1:0]  fill_rate_reg;
    logic [CAP_W-1:0]   cap_reg;
    logic [TOK_W-1:0]   token_reg;
    logic [TIME_W-1:0]  last_reg;
    logic               restart_reg;

    // Captured transaction and working registers
    logic               cmd_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [RATE_W-1:0]  mul_a_reg;
    logic [RATE_W-1:0]  mul_b_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic               sat_reg;
    logic [RATE_W-1:0]  rem_reg;
    logic [NEED_W-1:0]  quo_reg;
    logic [WAIT_W-1:0]  res_wait_reg;
    logic               res_grant_reg;
    logic               res_over_reg;
    logic [WAIT_W-1:0]  wait_reg;
    logic               granted_reg;
    logic               over_reg;

    logic [NEED_W-1:0]  need;
    logic [TOK_W-1:0]   cap_fixed;
    logic [SUM_W-1:0]   mul_sum;
    logic               mul_sat_next;
    logic [ACC_W-FRAC_BITS-QUARTER_SHIFT-1:0] cap_bytes;
    logic [CAP_W-1:0]   cap_calc;
    logic [TOK_W-1:0]   cap_calc_fixed;
    logic [TIME_W-1:0]  delta;
    logic [RATE_W-1:0]  delta_sat;
    logic [TOK_W+1:0]   tok_sum;
    logic [TOK_W-1:0]   refill_val;
    logic [RATE_W:0]    div_r2;
    logic               div_ge;
    logic [RATE_W:0]    div_diff;
    logic [NEED_W:0]    quo_up;
    logic [WAIT_W-1:0]  wait_calc;

    assign need      = {bytes_reg, {FRAC_BITS{1'b0}}};
    assign cap_fixed = {cap_reg, {FRAC_BITS{1'b0}}};

    // MSB-first shift-add; any product at or above 2^ACC_W is beyond every capacity
    assign mul_sum      = {1'b0, acc_reg, 1'b0}
                        + (mul_b_reg[RATE_W-1] ? SUM_W'(mul_a_reg) : SUM_W'(0));
    assign mul_sat_next = sat_reg | (|mul_sum[SUM_W-1:ACC_W]);

    // Capacity is a quarter second of rate in whole bytes
    assign cap_bytes = acc_reg[ACC_W-1:FRAC_BITS+QUARTER_SHIFT];
    always_comb
    begin
        if (fill_rate_reg == '0)
            cap_calc = '0;
        else if (sat_reg)
            cap_calc = CAP_MAX_BYTES;
        else if (CAP_W'(cap_bytes) < CAP_MIN_BYTES)
            cap_calc = CAP_MIN_BYTES;
        else
            cap_calc = CAP_W'(cap_bytes);
    end
    assign cap_calc_fixed = {cap_calc, {FRAC_BITS{1'b0}}};

    // Elapsed time beyond 40 bits always overfills the bucket
    assign delta     = now_reg - last_reg;
    assign delta_sat = (|delta[TIME_W-1:RATE_W]) ? '1 : delta[RATE_W-1:0];

    assign tok_sum    = {2'b00, token_reg} + {1'b0, acc_reg};
    assign refill_val = (sat_reg || tok_sum > (TOK_W+2)'(cap_fixed)) ? cap_fixed
                                                                      : tok_sum[TOK_W-1:0];

    // Restoring division, one quotient bit per cycle
    assign div_r2   = {rem_reg, quo_reg[NEED_W-1]};
    assign div_ge   = div_r2 >= {1'b0, fill_rate_reg};
    assign div_diff = div_r2 - {1'b0, fill_rate_reg};

    // Round up and saturate
    assign quo_up    = {1'b0, quo_reg} + (NEED_W+1)'(rem_reg != '0);
    assign wait_calc = (quo_up > (NEED_W+1)'(WAIT_MAX)) ? WAIT_MAX : quo_up[WAIT_W-1:0];

    assign status.is_fill   = cmd_reg;
    assign status.is_free   = (bytes_reg == '0) || (fill_rate_reg == '0);
    assign status.time_only = restart_reg || (now_reg <= last_reg);
    assign status.over      = bytes_reg > BYTES_W'(cap_reg);
    assign status.enough    = TIME_W'(token_reg) >= need;

    // Bucket state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_rate_reg <= '0;
            cap_reg       <= '0;
            token_reg     <= '0;
            last_reg      <= '0;
            restart_reg   <= 1'b1;
        end
        else if (fill_rate_we)
        begin
            fill_rate_reg <= fill_rate;
            restart_reg   <= 1'b1;
        end
        else
        begin
            unique case (op)
                OP_CFG_FINISH:
                begin
                    cap_reg <= cap_calc;
                    if (fill_rate_reg == '0)
                        token_reg <= '0;
                    else if (token_reg > cap_calc_fixed)
                        token_reg <= cap_calc_fixed;
                end
                OP_FILL:
                begin
                    token_reg   <= cap_fixed;
                    last_reg    <= now_reg;
                    restart_reg <= 1'b0;
                end
                OP_SET_TIME:
                begin
                    last_reg    <= now_reg;
                    restart_reg <= 1'b0;
                end
                OP_REFILL_START: last_reg  <= now_reg;
                OP_REFILL_ADD:   token_reg <= refill_val;
                OP_OVER:         token_reg <= '0;
                OP_GRANT:        token_reg <= token_reg - TOK_W'(need);
                default:         ;
            endcase
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        if (fill_rate_we)
        begin
            mul_a_reg <= fill_rate;
            mul_b_reg <= TPS_OPERAND;
            acc_reg   <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            unique case (op)
                OP_CAPTURE:
                begin
                    cmd_reg   <= cmd;
                    now_reg   <= now;
                    bytes_reg <= byte_count;
                end
                OP_MUL_STEP:
                begin
                    mul_b_reg <= {mul_b_reg[RATE_W-2:0], 1'b0};
                    sat_reg   <= mul_sat_next;
                    if (!mul_sat_next)
                        acc_reg <= mul_sum[ACC_W-1:0];
                end
                OP_REFILL_START:
                begin
                    mul_a_reg <= fill_rate_reg;
                    mul_b_reg <= delta_sat;
                    acc_reg   <= '0;
                    sat_reg   <= 1'b0;
                end
                OP_FILL:
                begin
                    res_wait_reg  <= '0;
                    res_grant_reg <= 1'b0;
                    res_over_reg  <= 1'b0;
                end
                OP_FREE, OP_GRANT:
                begin
                    res_wait_reg  <= '0;
                    res_grant_reg <= 1'b1;
                    res_over_reg  <= 1'b0;
                end
                OP_OVER:
                begin
                    rem_reg       <= '0;
                    quo_reg       <= need;
                    res_grant_reg <= 1'b0;
                    res_over_reg  <= 1'b1;
                end
                OP_SHORT:
                begin
                    rem_reg       <= '0;
                    quo_reg       <= need - NEED_W'(token_reg);
                    res_grant_reg <= 1'b0;
                    res_over_reg  <= 1'b0;
                end
                OP_DIV_STEP:
                begin
                    rem_reg <= div_ge ? div_diff[RATE_W-1:0] : div_r2[RATE_W-1:0];
                    quo_reg <= {quo_reg[NEED_W-2:0], div_ge};
                end
                OP_ROUND: res_wait_reg <= wait_calc;
                OP_PUBLISH:
                begin
                    wait_reg    <= res_wait_reg;
                    granted_reg <= res_grant_reg;
                    over_reg    <= res_over_reg;
                end
                default: ;
            endcase
        end
    end

    assign wait_ticks    = wait_reg;
    assign granted       = granted_reg;
    assign over_capacity = over_reg;

endmodule

[rtl/tbrl_ctrl.sv]
// Controller: sequences configuration and request work and owns the handshakes.
`timescale 1ns / 1ps

module tbrl_ctrl
    import tbrl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fill_rate_we,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_op_t     op
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CFG_MUL,
        S_CFG_DONE,
        S_START,
        S_REF_MUL,
        S_REF_ADD,
        S_CHECK,
        S_DIV,
        S_ROUND,
        S_DONE
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             out_valid_reg;
    logic             slot_free;
    logic             publish;
    logic             mul_last;
    logic             div_last;

    assign slot_free = !out_valid_reg || out_ready;
    assign publish   = (state_reg == S_DONE) && slot_free && !fill_rate_we;
    assign mul_last  = cnt_reg == CNT_W'(MUL_STEPS - 1);
    assign div_last  = cnt_reg == CNT_W'(DIV_STEPS - 1);
    assign in_ready  = (state_reg == S_IDLE) && !fill_rate_we;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        op = OP_NONE;
        unique case (state_reg)
            S_IDLE:     if (in_valid && in_ready) op = OP_CAPTURE;
            S_CFG_MUL:  op = OP_MUL_STEP;
            S_CFG_DONE: op = OP_CFG_FINISH;
            S_START:
            begin
                if (status.is_fill)
                    op = OP_FILL;
                else if (status.is_free)
                    op = OP_FREE;
                else if (status.time_only)
                    op = OP_SET_TIME;
                else
                    op = OP_REFILL_START;
            end
            S_REF_MUL:  op = OP_MUL_STEP;
            S_REF_ADD:  op = OP_REFILL_ADD;
            S_CHECK:
            begin
                if (status.over)
                    op = OP_OVER;
                else if (status.enough)
                    op = OP_GRANT;
                else
                    op = OP_SHORT;
            end
            S_DIV:      op = OP_DIV_STEP;
            S_ROUND:    op = OP_ROUND;
            S_DONE:     if (slot_free) op = OP_PUBLISH;
            default:    op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Load a new result, or drop the one the receiver just took
            if (publish)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            if (fill_rate_we)
            begin
                state_reg <= S_CFG_MUL;
                cnt_reg   <= '0;
            end
            else
            begin
                unique case (state_reg)
                    S_IDLE:
                        if (in_valid && in_ready)
                            state_reg <= S_START;
                    S_CFG_MUL:
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (mul_last)
                            state_reg <= S_CFG_DONE;
                    end
                    S_CFG_DONE:
                        state_reg <= S_IDLE;
                    S_START:
                    begin
                        cnt_reg <= '0;
                        if (status.is_fill || status.is_free)
                            state_reg <= S_DONE;
                        else if (status.time_only)
                            state_reg <= S_CHECK;
                        else
                            state_reg <= S_REF_MUL;
                    end
                    S_REF_MUL:
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (mul_last)
                            state_reg <= S_REF_ADD;
                    end
                    S_REF_ADD:
                        state_reg <= S_CHECK;
                    S_CHECK:
                    begin
                        cnt_reg <= '0;
                        if (!status.over && status.enough)
                            state_reg <= S_DONE;
                        else
                            state_reg <= S_DIV;
                    end
                    S_DIV:
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (div_last)
                            state_reg <= S_ROUND;
                    end
                    S_ROUND:
                        state_reg <= S_DONE;
                    S_DONE:
                        if (slot_free)
                            state_reg <= S_IDLE;
                    default:
                        state_reg <= S_IDLE;
                endcase
            end
        end
    end

endmodule

[rtl/tbrl_checker.sv]
// Port-level assertions for the token bucket rate limiter, bound to the top level.
`timescale 1ns / 1ps

module tbrl_checker
    import tbrl_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               fill_rate_we,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [WAIT_W-1:0]  wait_ticks,
    input logic               granted,
    input logic               over_capacity
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(wait_ticks)
            && $stable(granted) && $stable(over_capacity))
        else $error("result changed while stalled");

    // One transaction in work at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction accepted during work");

    // Rate write blocks intake while capacity is recomputed
    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        fill_rate_we |=> !in_ready)
        else $error("intake open during capacity update");

    // A grant carries no wait and no oversize flag
    a_grant_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && granted |-> wait_ticks == '0 && !over_capacity)
        else $error("grant with wait or oversize");

    // An oversized request always reports a nonzero wait
    a_over_waits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && over_capacity |-> wait_ticks != '0 && !granted)
        else $error("oversized request without wait");

endmodule

bind token_bucket_rate_limiter tbrl_checker u_tbrl_checker (.*);

[tb/tb_token_bucket_rate_limiter.sv]
// Self-checking testbench for the token bucket rate limiter: directed and random requests.
`timescale 1ns / 1ps

module tb_token_bucket_rate_limiter;
    import tbrl_pkg::*;

    localparam bit CMD_TAKE = 1'b0;
    localparam bit CMD_FILL = 1'b1;
    localparam int QUIET_LIMIT  = 2000;  // cycles with no transaction on either channel
    localparam int TAIL_CYCLES  = 120;   // settle time after the last result
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 165;
    localparam int PRINT_LIMIT  = 100;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [RATE_W-1:0] RATE_MAX = '1;

    typedef struct packed {
        logic                cmd;
        logic [TIME_W-1:0]   now;
        logic [BYTES_W-1:0]  byte_count;
    } request_t;

    typedef struct packed {
        logic [WAIT_W-1:0]   wait_ticks;
        logic                granted;
        logic                over_capacity;
    } verdict_t;

    // DUT connections; every input starts at a known value
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                fill_rate_we = 1'b0;
    logic [RATE_W-1:0]   fill_rate = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                cmd = 1'b0;
    logic [TIME_W-1:0]   now = '0;
    logic [BYTES_W-1:0]  byte_count = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [WAIT_W-1:0]   wait_ticks;
    logic                granted;
    logic                over_capacity;

    // bucket state mirrored by the predictor
    bit [63:0] rate_q;
    bit [63:0] tokens;
    bit [63:0] stamp;
    bit [63:0] cap_bytes;
    bit        restart;

    request_t  request_q[$];
    verdict_t  verdict_q[$];

    int  errors;
    int  results_seen;
    int  send_gap;
    int  stall_left;
    int  quiet;
    bit  steady;       // no idling on either side in the final phase

    token_bucket_rate_limiter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .fill_rate_we  (fill_rate_we),
        .fill_rate     (fill_rate),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .now           (now),
        .byte_count    (byte_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .wait_ticks    (wait_ticks),
        .granted       (granted),
        .over_capacity (over_capacity)
    );

    always #5 clk = ~clk;

    // Capacity in whole bytes: a quarter second of rate, clamped to 64 KiB..8 MiB.
    function automatic bit [63:0] bucket_capacity(input bit [63:0] r);
        bit [63:0] b;
        if (r == 0)
            return 64'd0;
        if ((r >> FRAC_BITS) * 64'(TICKS_PER_SECOND) >= (64'(CAP_MAX_BYTES) << QUARTER_SHIFT))
            return 64'(CAP_MAX_BYTES);
        b = (r * 64'(TICKS_PER_SECOND)) >> (FRAC_BITS + QUARTER_SHIFT);
        if (b < 64'(CAP_MIN_BYTES))
            b = 64'(CAP_MIN_BYTES);
        if (b > 64'(CAP_MAX_BYTES))
            b = 64'(CAP_MAX_BYTES);
        return b;
    endfunction

    // Ticks to cover a Q.16 shortfall at the current rate, rounded up and saturated.
    function automatic logic [WAIT_W-1:0] wait_for(input bit [63:0] shortfall);
        bit [63:0] q;
        q = shortfall / rate_q;
        if (q * rate_q != shortfall)
            q++;
        if (q > 64'(WAIT_MAX))
            q = 64'(WAIT_MAX);
        return q[WAIT_W-1:0];
    endfunction

    // Advance the mirrored bucket by one transaction and return its verdict.
    function automatic verdict_t bucket_take(input logic c_i, input logic [TIME_W-1:0] t_i,
                                             input logic [BYTES_W-1:0] b_i);
        verdict_t  v;
        bit [63:0] need;
        bit [63:0] full;
        bit [63:0] delta;
        v     = '0;
        need  = 64'(b_i) << FRAC_BITS;
        full  = cap_bytes << FRAC_BITS;
        if (c_i == CMD_FILL) begin
            tokens  = full;
            stamp   = 64'(t_i);
            restart = 1'b0;
            return v;
        end
        if (b_i == 0 || rate_q == 0) begin
            v.granted = 1'b1;
            return v;
        end
        // refill: restart and backwards time only move the time base
        if (restart) begin
            restart = 1'b0;
            stamp   = 64'(t_i);
        end else if (64'(t_i) <= stamp) begin
            stamp = 64'(t_i);
        end else begin
            delta = 64'(t_i) - stamp;
            stamp = 64'(t_i);
            if (delta > full / rate_q)
                tokens = full;
            else begin
                tokens = tokens + delta * rate_q;
                if (tokens > full)
                    tokens = full;
            end
        end
        if (64'(b_i) > cap_bytes) begin
            tokens          = 64'd0;
            v.wait_ticks    = wait_for(need);
            v.over_capacity = 1'b1;
        end else if (tokens >= need) begin
            tokens    = tokens - need;
            v.granted = 1'b1;
        end else begin
            v.wait_ticks = wait_for(need - tokens);
        end
        return v;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("MISMATCH %s on result %0d: expected %0h, got %0h",
                     field, results_seen, want, got);
    endtask

    task automatic queue_request(input logic c_i, input logic [TIME_W-1:0] t_i,
                                 input logic [BYTES_W-1:0] b_i);
        request_t r;
        r.cmd        = c_i;
        r.now        = t_i;
        r.byte_count = b_i;
        request_q.push_back(r);
    endtask

    // Block until nothing is queued, presented or outstanding. Sample on the falling
    // edge so the driver's pop at the rising edge cannot be missed.
    task automatic wait_drained();
        @(negedge clk);
        while (request_q.size() != 0 || in_valid || verdict_q.size() != 0)
            @(negedge clk);
    endtask

    // Write the rate while idle and mirror the register side effects.
    task automatic write_rate(input logic [RATE_W-1:0] r);
        wait_drained();
        @(posedge clk);
        fill_rate_we <= 1'b1;
        fill_rate    <= r;
        rate_q    = 64'(r);
        cap_bytes = bucket_capacity(rate_q);
        if (rate_q == 0)
            tokens = 64'd0;
        else if (tokens > (cap_bytes << FRAC_BITS))
            tokens = cap_bytes << FRAC_BITS;
        restart = 1'b1;
        @(posedge clk);
        fill_rate_we <= 1'b0;
    endtask

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(5, 0))
            0:       return RATE_W'($urandom_range(65535, 1));
            1:       return RATE_W'($urandom_range(2200000, 17000));   // capacity clamped only near the range ends
            2:       return RATE_W'({$urandom, $urandom});
            3:       return RATE_MAX;
            4:       return RATE_W'($urandom_range(255, 1));           // wait can saturate
            default: return RATE_W'($urandom_range(40000000, 2200000));
        endcase
    endfunction

    // Driver: hold each transaction until accepted, then present the next one after an
    // optional idle burst. The verdict is predicted at acceptance so it follows the
    // same order as the block's own state.
    always @(posedge clk) begin : drive
        logic     slot_free;
        request_t req;
        if (rst_n) begin
            slot_free = !in_valid;
            if (in_valid && in_ready) begin
                verdict_q.push_back(bucket_take(cmd, now, byte_count));
                slot_free = 1'b1;
            end
            if (slot_free) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (!steady && $urandom_range(9, 0) == 0) begin
                    send_gap = $urandom_range(17, 0);
                    in_valid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    req = request_q.pop_front();
                    in_valid   <= 1'b1;
                    cmd        <= req.cmd;
                    now        <= req.now;
                    byte_count <= req.byte_count;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare every accepted result with the oldest prediction; stall the
    // output channel in random bursts.
    always @(posedge clk) begin : watch_out
        verdict_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (verdict_q.size() == 0)
                    report_mismatch("unexpected result", 64'd0, 64'(wait_ticks));
                else begin
                    want = verdict_q.pop_front();
                    if (wait_ticks !== want.wait_ticks)
                        report_mismatch("wait_ticks", 64'(want.wait_ticks), 64'(wait_ticks));
                    if (granted !== want.granted)
                        report_mismatch("granted", 64'(want.granted), 64'(granted));
                    if (over_capacity !== want.over_capacity)
                        report_mismatch("over_capacity", 64'(want.over_capacity),
                                        64'(over_capacity));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (!steady && $urandom_range(7, 0) == 0) begin
                stall_left = $urandom_range(17, 0);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin : stimulus
        bit [63:0]          c;
        bit [63:0]          fillt;
        bit [TIME_W-1:0]    t;
        bit [BYTES_W-1:0]   nbytes;
        int unsigned        span;
        logic               op;
        rate_q    = 64'd0;
        tokens    = 64'd0;
        stamp     = 64'd0;
        cap_bytes = 64'd0;
        restart   = 1'b1;
        errors    = 0;
        results_seen = 0;
        send_gap  = 0;
        stall_left = 0;
        quiet     = 0;
        steady    = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Unlimited rate out of reset: takes pass at once, fill with zero capacity.
        queue_request(CMD_TAKE, 48'd5, 32'd100);
        queue_request(CMD_FILL, 48'd10, 32'd0);
        queue_request(CMD_TAKE, 48'd12, 32'd0);

        // One byte per tick: restart, refill, backwards time, oversize, zero bytes,
        // fill, take of exactly capacity, huge elapsed time, largest request.
        write_rate(RATE_W'(1 << FRAC_BITS));
        queue_request(CMD_TAKE, 48'd1000, 32'd10);
        queue_request(CMD_TAKE, 48'd1010, 32'd10);
        queue_request(CMD_TAKE, 48'd1005, 32'd5);
        queue_request(CMD_TAKE, 48'd1006, 32'd300000);
        queue_request(CMD_TAKE, 48'd1007, 32'd0);
        queue_request(CMD_FILL, 48'd2000, 32'hFFFF_FFFF);
        queue_request(CMD_TAKE, 48'd2000, 32'd250000);
        queue_request(CMD_TAKE, TIME_MAX, 32'd1);
        queue_request(CMD_TAKE, TIME_MAX, 32'hFFFF_FFFF);

        // Smallest rate: minimum capacity and a saturated wait.
        write_rate(RATE_W'(1));
        queue_request(CMD_TAKE, 48'd0, 32'hFFFF_FFFF);
        queue_request(CMD_FILL, TIME_MAX, 32'd0);
        queue_request(CMD_TAKE, TIME_MAX, 32'd65536);
        queue_request(CMD_TAKE, TIME_MAX, 32'd1);

        // Largest rate: maximum capacity, one tick fills the bucket.
        write_rate(RATE_MAX);
        queue_request(CMD_TAKE, 48'd0, 32'd1);
        queue_request(CMD_TAKE, 48'd1, 32'd8388608);
        queue_request(CMD_TAKE, 48'd2, 32'd8388609);
        queue_request(CMD_FILL, 48'd3, 32'd0);

        // Back to unlimited from a full bucket: tokens drop to zero.
        write_rate('0);
        queue_request(CMD_TAKE, 48'd4, 32'd5);

        for (int ph = 0; ph < PHASES; ph++) begin
            write_rate(pick_rate());
            if (ph == PHASES - 1)
                steady = 1'b1;
            c = cap_bytes;
            // time needed to fill an empty bucket sets the scale of the time steps
            if (rate_q != 0) begin
                fillt = (c << FRAC_BITS) / rate_q;
                span  = (fillt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(fillt);
            end else
                span = 1000;
            if (span == 0)
                span = 4;
            t = ($urandom_range(1, 0) == 0) ? TIME_W'({$urandom, $urandom})
                                              : TIME_W'($urandom_range(1000, 0));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // hold off once until the block has returned everything
                if (ph == 4 && i == PHASE_ITEMS / 2)
                    wait_drained();
                case ($urandom_range(15, 0))
                    0:       t = TIME_W'({$urandom, $urandom});
                    1:       t = t - TIME_W'($urandom_range(50, 0));
                    2, 3:    t = t + TIME_W'($urandom_range(5, 0));
                    4, 5:    t = t + TIME_W'($urandom_range(span, span / 2));
                    default: t = t + TIME_W'($urandom_range(span / 4, 0));
                endcase
                case ($urandom_range(15, 0))
                    0:       nbytes = 32'd0;
                    1:       nbytes = $urandom;
                    2:       nbytes = 32'(c);
                    3:       nbytes = 32'(c + 1);
                    4:       nbytes = $urandom_range(32'(2 * c + 1), 32'(c));
                    5, 6:    nbytes = $urandom_range(64, 1);
                    default: nbytes = $urandom_range(32'(c), 0);
                endcase
                op = ($urandom_range(11, 0) == 0) ? CMD_FILL : CMD_TAKE;
                queue_request(op, t, nbytes);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && verdict_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
rtl/tbrl_pkg.sv
rtl/tbrl_datapath.sv
rtl/tbrl_ctrl.sv
rtl/token_bucket_rate_limiter.sv
rtl/tbrl_checker.sv
tb/tb_token_bucket_rate_limiter.sv
